[design/bba_pkg.sv]
// shared types and constants of the bitmap block allocator
package bba_pkg;

	localparam int unsigned MAX_BLOCKS    = 65536;
	localparam int unsigned MAP_WORD_BITS = 64;
	localparam int unsigned MAP_WORDS     = MAX_BLOCKS / MAP_WORD_BITS;
	localparam int unsigned WORD_AW       = $clog2(MAP_WORDS);
	localparam int unsigned BIT_W         = $clog2(MAP_WORD_BITS);
	localparam int unsigned BLK_W         = 16;
	localparam int unsigned CNT_W         = 17;
	localparam int unsigned GRP_BITS      = 8;
	localparam int unsigned GROUPS        = MAP_WORD_BITS / GRP_BITS;
	localparam int unsigned GRP_W         = $clog2(GROUPS);
	localparam int unsigned GBIT_W        = $clog2(GRP_BITS);

	localparam logic [CNT_W-1:0]   MAX_COUNT = CNT_W'(MAX_BLOCKS);
	localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);

	typedef logic [MAP_WORD_BITS-1:0] map_word_t;

	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_FORMAT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK           = 2'd0,
		STAT_FULL         = 2'd1,
		STAT_RANGE        = 2'd2,
		STAT_ALREADY_FREE = 2'd3
	} status_t;

	typedef enum logic {
		REG_TOTAL    = 1'b0,
		REG_RESERVED = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_ALLOC,
		ST_RESP
	} state_t;

endpackage

[design/bitmap_block_allocator.sv]
// bitmap block allocator: usage map memory, free count and command sequencer
//
// One command beat enters on in_valid/in_stall (command, block_number), one result
// beat leaves on out_valid/out_stall (result_block, bit_state, status, free_blocks).
// Registers total_blocks (index 0) and reserved_blocks (index 1) are written via cfg_we/
// cfg_index/cfg_data, by the user only while no command is in flight; not enforced.
// The map is a 1024 x 64 bit memory with one read and one write port; commands are
// handled one at a time and in_stall is high until the sequencer is back in idle.
// Allocate scans the map one word per cycle, up to 1024 words, and stops at the first
// word with a free bit; format writes one map word per cycle.
// An allocate at zero free count and an out of range free or query skip the map access.
// After reset the map is cleared by the same sweep, during which no command is taken;
// configuration writes are taken throughout.
// The output register frees the sequencer: a new command is taken while a result
// waits on out_stall; the next result waits in the sequencer until the register empties.
module bitmap_block_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [bba_pkg::CNT_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  command,
	input  logic [bba_pkg::BLK_W-1:0]   block_number,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bba_pkg::BLK_W-1:0]   result_block,
	output logic                        bit_state,
	output logic [1:0]                  status,
	output logic [bba_pkg::CNT_W-1:0]   free_blocks
);

	bba_pkg::state_t state_q, state_d;

	logic [bba_pkg::CNT_W-1:0]   total_q, reserved_q;
	logic [bba_pkg::CNT_W-1:0]   eff_total, res_clamp;
	logic [bba_pkg::CNT_W-1:0]   free_count_q, free_count_d;
	logic [bba_pkg::CNT_W-1:0]   fmt_res_q, fmt_res_d;
	logic                        fmt_q, fmt_d;
	logic [bba_pkg::WORD_AW-1:0] addr_q, addr_d;
	logic [bba_pkg::WORD_AW-1:0] chk_addr_q;
	logic                        rd_valid_q;
	bba_pkg::map_word_t          rdata_q;
	bba_pkg::map_word_t          alloc_word_q, alloc_word_d;
	logic [bba_pkg::BLK_W-1:0]   found_q, found_d;
	logic [bba_pkg::BLK_W-1:0]   blk_q, blk_d;
	bba_pkg::cmd_t               cmd_q, cmd_d;
	logic [bba_pkg::BLK_W-1:0]   res_block_q, res_block_d;
	logic                        res_bit_q, res_bit_d;
	bba_pkg::status_t            res_status_q, res_status_d;
	logic                        out_valid_q;
	logic                        out_load;

	bba_pkg::map_word_t          map_mem [bba_pkg::MAP_WORDS];
	logic                        mem_we;
	logic [bba_pkg::WORD_AW-1:0] mem_waddr, mem_raddr;
	bba_pkg::map_word_t          mem_wdata;

	bba_pkg::map_word_t          sweep_word;
	bba_pkg::map_word_t          zero_bits;
	logic [bba_pkg::GROUPS-1:0]  grp_nz;
	logic [bba_pkg::GRP_W-1:0]   grp_sel;
	logic [bba_pkg::GRP_BITS-1:0] grp_bits;
	logic [bba_pkg::GBIT_W-1:0]  gbit_sel;
	logic                        any_zero;
	logic                        cur_bit;
	logic                        alloc_ok;
	logic                        in_beat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= bba_pkg::MAX_COUNT;
			reserved_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == bba_pkg::REG_TOTAL) begin
				total_q <= cfg_data;
			end else begin
				reserved_q <= cfg_data;
			end
		end
	end

	assign eff_total = (total_q > bba_pkg::MAX_COUNT) ? bba_pkg::MAX_COUNT : total_q;
	assign res_clamp = (reserved_q > eff_total) ? eff_total : reserved_q;

	// map word written by the clear and format sweep
	always_comb begin
		if ({1'b0, addr_q} < fmt_res_q[bba_pkg::CNT_W-1:bba_pkg::BIT_W]) begin
			sweep_word = '1;
		end else if ({1'b0, addr_q} == fmt_res_q[bba_pkg::CNT_W-1:bba_pkg::BIT_W]) begin
			sweep_word = ~({bba_pkg::MAP_WORD_BITS{1'b1}} << fmt_res_q[bba_pkg::BIT_W-1:0]);
		end else begin
			sweep_word = '0;
		end
	end

	// lowest free bit of the scanned word: first group, then bit within group
	always_comb begin
		zero_bits = ~rdata_q;
		grp_sel   = '0;
		gbit_sel  = '0;
		for (int g = 0; g < bba_pkg::GROUPS; g++) begin
			grp_nz[g] = |zero_bits[g*bba_pkg::GRP_BITS +: bba_pkg::GRP_BITS];
		end
		for (int g = bba_pkg::GROUPS - 1; g >= 0; g--) begin
			if (grp_nz[g]) begin
				grp_sel = bba_pkg::GRP_W'(g);
			end
		end
		grp_bits = zero_bits[grp_sel*bba_pkg::GRP_BITS +: bba_pkg::GRP_BITS];
		for (int b = bba_pkg::GRP_BITS - 1; b >= 0; b--) begin
			if (grp_bits[b]) begin
				gbit_sel = bba_pkg::GBIT_W'(b);
			end
		end
		any_zero = |grp_nz;
	end

	assign cur_bit   = rdata_q[blk_q[bba_pkg::BIT_W-1:0]];
	assign alloc_ok  = {1'b0, found_q} < eff_total;
	assign in_stall  = (state_q != bba_pkg::ST_IDLE);
	assign in_beat   = in_valid && !in_stall;
	assign out_load  = (state_q == bba_pkg::ST_RESP) && (!out_valid_q || !out_stall);
	assign mem_raddr = (state_q == bba_pkg::ST_SCAN) ? addr_q
		: block_number[bba_pkg::BLK_W-1:bba_pkg::BIT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory port and register updates
	always_comb begin
		state_d      = state_q;
		free_count_d = free_count_q;
		fmt_res_d    = fmt_res_q;
		fmt_d        = fmt_q;
		addr_d       = addr_q;
		alloc_word_d = alloc_word_q;
		found_d      = found_q;
		blk_d        = blk_q;
		cmd_d        = cmd_q;
		res_block_d  = res_block_q;
		res_bit_d    = res_bit_q;
		res_status_d = res_status_q;
		mem_we       = 1'b0;
		mem_waddr    = addr_q;
		mem_wdata    = sweep_word;
		unique case (state_q)
			bba_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				addr_d = addr_q + 1'b1;
				if (addr_q == bba_pkg::LAST_WORD) begin
					state_d = fmt_q ? bba_pkg::ST_RESP : bba_pkg::ST_IDLE;
				end
			end
			bba_pkg::ST_IDLE: begin
				if (in_beat) begin
					cmd_d        = bba_pkg::cmd_t'(command);
					blk_d        = block_number;
					res_block_d  = '0;
					res_bit_d    = 1'b0;
					res_status_d = bba_pkg::STAT_OK;
					addr_d       = '0;
					unique case (bba_pkg::cmd_t'(command))
						bba_pkg::CMD_ALLOC: begin
							if (free_count_q == '0) begin
								res_status_d = bba_pkg::STAT_FULL;
								state_d      = bba_pkg::ST_RESP;
							end else begin
								state_d = bba_pkg::ST_SCAN;
							end
						end
						bba_pkg::CMD_FREE, bba_pkg::CMD_QUERY: begin
							res_block_d = block_number;
							if ({1'b0, block_number} >= eff_total) begin
								res_status_d = bba_pkg::STAT_RANGE;
								state_d      = bba_pkg::ST_RESP;
							end else begin
								state_d = bba_pkg::ST_READ;
							end
						end
						bba_pkg::CMD_FORMAT: begin
							fmt_res_d    = res_clamp;
							free_count_d = eff_total - res_clamp;
							fmt_d        = 1'b1;
							state_d      = bba_pkg::ST_CLEAR;
						end
						default: state_d = bba_pkg::ST_RESP;
					endcase
				end
			end
			bba_pkg::ST_READ: begin
				state_d = bba_pkg::ST_RESP;
				if (cmd_q == bba_pkg::CMD_QUERY) begin
					res_bit_d = cur_bit;
				end else if (!cur_bit) begin
					res_status_d = bba_pkg::STAT_ALREADY_FREE;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = blk_q[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
					mem_wdata = rdata_q
						& ~(bba_pkg::map_word_t'(1) << blk_q[bba_pkg::BIT_W-1:0]);
					if (free_count_q < bba_pkg::MAX_COUNT) begin
						free_count_d = free_count_q + 1'b1;
					end
				end
			end
			bba_pkg::ST_SCAN: begin
				addr_d = addr_q + 1'b1;
				if (rd_valid_q) begin
					if (any_zero) begin
						found_d      = {chk_addr_q, grp_sel, gbit_sel};
						alloc_word_d = rdata_q;
						state_d      = bba_pkg::ST_ALLOC;
					end else if (chk_addr_q == bba_pkg::LAST_WORD) begin
						res_status_d = bba_pkg::STAT_FULL;
						state_d      = bba_pkg::ST_RESP;
					end
				end
			end
			bba_pkg::ST_ALLOC: begin
				state_d = bba_pkg::ST_RESP;
				if (alloc_ok) begin
					mem_we      = 1'b1;
					mem_waddr   = found_q[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
					mem_wdata   = alloc_word_q
						| (bba_pkg::map_word_t'(1) << found_q[bba_pkg::BIT_W-1:0]);
					res_block_d = found_q;
					if (free_count_q != '0) begin
						free_count_d = free_count_q - 1'b1;
					end
				end else begin
					res_status_d = bba_pkg::STAT_FULL;
				end
			end
			bba_pkg::ST_RESP: begin
				fmt_d = 1'b0;
				if (out_load) begin
					state_d = bba_pkg::ST_IDLE;
				end
			end
			default: state_d = bba_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count_q <= bba_pkg::MAX_COUNT;
			fmt_res_q    <= '0;
			fmt_q        <= 1'b0;
			addr_q       <= '0;
			rd_valid_q   <= 1'b0;
		end else begin
			free_count_q <= free_count_d;
			fmt_res_q    <= fmt_res_d;
			fmt_q        <= fmt_d;
			addr_q       <= addr_d;
			rd_valid_q   <= (state_q == bba_pkg::ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		chk_addr_q   <= mem_raddr;
		alloc_word_q <= alloc_word_d;
		found_q      <= found_d;
		blk_q        <= blk_d;
		cmd_q        <= cmd_d;
		res_block_q  <= res_block_d;
		res_bit_q    <= res_bit_d;
		res_status_q <= res_status_d;
	end

	// usage map memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= map_mem[mem_raddr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_block <= res_block_q;
			bit_state    <= res_bit_q;
			status       <= res_status_q;
			free_blocks  <= free_count_q;
		end
	end

	assign out_valid = out_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= bba_pkg::MAX_COUNT)
		else $error("free count above block limit");

	a_zero_count_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && command == bba_pkg::CMD_ALLOC && free_count_q == '0
		|=> state_q == bba_pkg::ST_RESP && res_status_q == bba_pkg::STAT_FULL)
		else $error("allocate with zero free count did not report full");

	a_alloc_dec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bba_pkg::ST_ALLOC && alloc_ok && free_count_q != '0
		|=> free_count_q == $past(free_count_q) - 1'b1)
		else $error("allocation did not take one block from the count");

	a_full_block_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bba_pkg::STAT_FULL |-> result_block == '0)
		else $error("full result carries a block number");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bba_pkg::ST_SCAN && rd_valid_q
		|-> chk_addr_q == addr_q - 1'b1)
		else $error("scan checked a word out of order");

endmodule

[verif/tb_bitmap_block_allocator.sv]
// self-checking testbench of the bitmap block allocator with a bit-exact allocation predictor
module tb_bitmap_block_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS = 545;
	localparam int unsigned CYCLE_LIMIT  = 4000000;
	localparam int unsigned END_WAIT     = 1100;

	typedef struct {
		bba_pkg::cmd_t             cmd;
		logic [bba_pkg::BLK_W-1:0] block;
	} alloc_request_t;

	typedef struct {
		logic [bba_pkg::BLK_W-1:0] block;
		logic                      used_bit;
		bba_pkg::status_t          stat;
		logic [bba_pkg::CNT_W-1:0] count;
	} alloc_reply_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic                      cfg_index = bba_pkg::REG_TOTAL;
	logic [bba_pkg::CNT_W-1:0] cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                command = bba_pkg::CMD_ALLOC;
	logic [bba_pkg::BLK_W-1:0] block_number = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [bba_pkg::BLK_W-1:0] result_block;
	logic                      bit_state;
	logic [1:0]                status;
	logic [bba_pkg::CNT_W-1:0] free_blocks;

	bitmap_block_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.block_number (block_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_block (result_block),
		.bit_state    (bit_state),
		.status       (status),
		.free_blocks  (free_blocks)
	);

	bba_pkg::map_word_t model_map [bba_pkg::MAP_WORDS];
	int unsigned    model_total = bba_pkg::MAX_BLOCKS;
	int unsigned    model_reserved = 0;
	int unsigned    model_free = bba_pkg::MAX_BLOCKS;

	alloc_request_t queued_commands [$];
	alloc_reply_t   predicted_replies [$];
	alloc_reply_t   oldest_reply;
	bit             idle_on = 1'b1;
	int unsigned    send_gap = 0;
	int unsigned    hold_gap = 0;
	int unsigned    fail_count = 0;
	int unsigned    cycle_count = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned managed_blocks();
		return (model_total > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS : model_total;
	endfunction

	function automatic alloc_reply_t predict_command(alloc_request_t req);
		alloc_reply_t       r;
		int unsigned        lim;
		int unsigned        res;
		int unsigned        pos;
		int unsigned        wi;
		int unsigned        bi;
		bit                 hit;
		bba_pkg::map_word_t avail;
		lim = managed_blocks();
		r.block = '0;
		r.used_bit = 1'b0;
		r.stat = bba_pkg::STAT_OK;
		hit = 1'b0;
		pos = 0;
		wi = req.block / bba_pkg::MAP_WORD_BITS;
		bi = req.block % bba_pkg::MAP_WORD_BITS;
		case (req.cmd)
			bba_pkg::CMD_ALLOC: begin
				if (model_free != 0) begin
					for (int w = 0; w < bba_pkg::MAP_WORDS && !hit; w++) begin
						avail = ~model_map[w];
						if (avail != '0) begin
							hit = 1'b1;
							pos = w * bba_pkg::MAP_WORD_BITS;
							while (!avail[0]) begin
								avail = avail >> 1;
								pos++;
							end
						end
					end
				end
				if (hit && pos < lim) begin
					model_map[pos / bba_pkg::MAP_WORD_BITS][pos % bba_pkg::MAP_WORD_BITS] = 1'b1;
					if (model_free > 0)
						model_free--;
					r.block = bba_pkg::BLK_W'(pos);
				end else begin
					r.stat = bba_pkg::STAT_FULL;
				end
			end
			bba_pkg::CMD_FREE: begin
				r.block = req.block;
				if (req.block >= lim) begin
					r.stat = bba_pkg::STAT_RANGE;
				end else if (!model_map[wi][bi]) begin
					r.stat = bba_pkg::STAT_ALREADY_FREE;
				end else begin
					model_map[wi][bi] = 1'b0;
					if (model_free < bba_pkg::MAX_BLOCKS)
						model_free++;
				end
			end
			bba_pkg::CMD_QUERY: begin
				r.block = req.block;
				if (req.block >= lim)
					r.stat = bba_pkg::STAT_RANGE;
				else
					r.used_bit = model_map[wi][bi];
			end
			default: begin
				res = (model_reserved > lim) ? lim : model_reserved;
				foreach (model_map[w])
					model_map[w] = '0;
				for (int unsigned i = 0; i < res; i++)
					model_map[i / bba_pkg::MAP_WORD_BITS][i % bba_pkg::MAP_WORD_BITS] = 1'b1;
				model_free = lim - res;
			end
		endcase
		r.count = bba_pkg::CNT_W'(model_free);
		return r;
	endfunction

	function automatic logic [bba_pkg::BLK_W-1:0] pick_block(int unsigned hint,
		int unsigned lim);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return bba_pkg::BLK_W'($urandom_range(0, (hint > 65535) ? 65535 : hint));
		if (r < 85 && lim > 0)
			return bba_pkg::BLK_W'($urandom_range(0, lim - 1));
		return bba_pkg::BLK_W'($urandom);
	endfunction

	task automatic issue(bba_pkg::cmd_t c, logic [bba_pkg::BLK_W-1:0] b);
		queued_commands.push_back('{cmd: c, block: b});
	endtask

	task automatic wait_idle();
		while (queued_commands.size() != 0 || in_valid || predicted_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(bba_pkg::reg_idx_t idx, logic [bba_pkg::CNT_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		if (idx == bba_pkg::REG_TOTAL)
			model_total = v;
		else
			model_reserved = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// command driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				predicted_replies.push_back(predict_command(
					'{cmd: bba_pkg::cmd_t'(command), block: block_number}));
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 14);
					in_valid <= 1'b0;
				end else if (queued_commands.size() > 0) begin
					command <= queued_commands[0].cmd;
					block_number <= queued_commands[0].block;
					queued_commands.delete(0);
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (predicted_replies.size() == 0) begin
					$error("result beat with nothing pending: result_block %0d", result_block);
					fail_count++;
				end else begin
					oldest_reply = predicted_replies.pop_front();
					if (result_block !== oldest_reply.block) begin
						$error("result_block: expected %0d actual %0d", oldest_reply.block,
							result_block);
						fail_count++;
					end
					if (bit_state !== oldest_reply.used_bit) begin
						$error("bit_state: expected %0d actual %0d", oldest_reply.used_bit,
							bit_state);
						fail_count++;
					end
					if (status !== oldest_reply.stat) begin
						$error("status: expected %0d actual %0d", oldest_reply.stat, status);
						fail_count++;
					end
					if (free_blocks !== oldest_reply.count) begin
						$error("free_blocks: expected %0d actual %0d", oldest_reply.count,
							free_blocks);
						fail_count++;
					end
				end
			end
			if (hold_gap > 0) begin
				hold_gap--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				hold_gap = $urandom_range(0, 14);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned               done_items;
		int unsigned               phase_len;
		int unsigned               lim;
		int unsigned               res_lim;
		int unsigned               used_hint;
		int unsigned               pick;
		logic [bba_pkg::CNT_W-1:0] tot;
		logic [bba_pkg::CNT_W-1:0] rsv;

		foreach (model_map[w])
			model_map[w] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// fresh map at the reset defaults
		issue(bba_pkg::CMD_QUERY, 16'd0);
		issue(bba_pkg::CMD_ALLOC, 16'hFFFF);
		issue(bba_pkg::CMD_ALLOC, 16'd0);
		issue(bba_pkg::CMD_QUERY, 16'd1);
		issue(bba_pkg::CMD_FREE, 16'd0);
		issue(bba_pkg::CMD_FREE, 16'd0);
		issue(bba_pkg::CMD_ALLOC, 16'h1234);
		issue(bba_pkg::CMD_QUERY, 16'hFFFF);
		issue(bba_pkg::CMD_FREE, 16'hFFFF);
		// reserved above total, zero count with free bits left in the map
		wait_idle();
		write_reg(bba_pkg::REG_TOTAL, 17'd10);
		write_reg(bba_pkg::REG_RESERVED, 17'h1FFFF);
		issue(bba_pkg::CMD_FORMAT, 16'hA5A5);
		issue(bba_pkg::CMD_ALLOC, 16'd0);
		issue(bba_pkg::CMD_QUERY, 16'd10);
		issue(bba_pkg::CMD_FREE, 16'hFFFF);
		issue(bba_pkg::CMD_FREE, 16'd3);
		issue(bba_pkg::CMD_ALLOC, 16'd0);
		// saturating total, kept map and count
		wait_idle();
		write_reg(bba_pkg::REG_TOTAL, 17'h1FFFF);
		issue(bba_pkg::CMD_ALLOC, 16'd0);
		issue(bba_pkg::CMD_QUERY, 16'hFFFF);
		// nothing managed
		wait_idle();
		write_reg(bba_pkg::REG_TOTAL, 17'd0);
		write_reg(bba_pkg::REG_RESERVED, 17'd0);
		issue(bba_pkg::CMD_FORMAT, 16'd0);
		issue(bba_pkg::CMD_ALLOC, 16'd0);
		issue(bba_pkg::CMD_QUERY, 16'd0);
		// first free block at or above a shrunk total
		wait_idle();
		write_reg(bba_pkg::REG_TOTAL, 17'd3);
		write_reg(bba_pkg::REG_RESERVED, 17'd1);
		issue(bba_pkg::CMD_FORMAT, 16'd0);
		issue(bba_pkg::CMD_ALLOC, 16'd0);
		wait_idle();
		write_reg(bba_pkg::REG_TOTAL, 17'd2);
		issue(bba_pkg::CMD_ALLOC, 16'd0);
		// full map, all reserved
		wait_idle();
		write_reg(bba_pkg::REG_TOTAL, 17'd65536);
		write_reg(bba_pkg::REG_RESERVED, 17'd65536);
		issue(bba_pkg::CMD_FORMAT, 16'd0);
		issue(bba_pkg::CMD_FREE, 16'hFFFF);
		issue(bba_pkg::CMD_ALLOC, 16'd0);
		used_hint = 65535;

		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			wait_idle();
			case ($urandom_range(0, 5))
				0: tot = bba_pkg::CNT_W'($urandom_range(1, 64));
				1: tot = bba_pkg::CNT_W'($urandom_range(65, 2000));
				2: tot = bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS);
				3: tot = bba_pkg::CNT_W'($urandom_range(65537, 131071));
				4: tot = bba_pkg::CNT_W'($urandom);
				default: tot = ($urandom_range(0, 3) == 0) ? '0
					: bba_pkg::CNT_W'($urandom_range(1, 16));
			endcase
			lim = (tot > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS : tot;
			case ($urandom_range(0, 4))
				0: rsv = '0;
				1: rsv = bba_pkg::CNT_W'($urandom_range(0, 300));
				2: rsv = 17'h1FFFF;
				3: rsv = bba_pkg::CNT_W'($urandom);
				default: rsv = bba_pkg::CNT_W'(lim);
			endcase
			res_lim = (rsv > lim) ? lim : rsv;
			write_reg(bba_pkg::REG_TOTAL, tot);
			write_reg(bba_pkg::REG_RESERVED, rsv);
			phase_len = $urandom_range(20, 60);
			if (RANDOM_ITEMS - done_items <= 60) begin
				phase_len = RANDOM_ITEMS - done_items;
				idle_on = 1'b0;
			end else begin
				idle_on = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 3) != 0) begin
				issue(bba_pkg::CMD_FORMAT, bba_pkg::BLK_W'($urandom));
				used_hint = res_lim;
			end
			for (int k = 0; k < phase_len; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 42) begin
					issue(bba_pkg::CMD_ALLOC, bba_pkg::BLK_W'($urandom));
					used_hint++;
				end else if (pick < 67) begin
					issue(bba_pkg::CMD_FREE, pick_block(used_hint, lim));
				end else if (pick < 92) begin
					issue(bba_pkg::CMD_QUERY, pick_block(used_hint, lim));
				end else begin
					issue(bba_pkg::CMD_FORMAT, bba_pkg::BLK_W'($urandom));
					used_hint = res_lim;
				end
			end
			done_items += phase_len;
		end

		wait_idle();
		repeat (END_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[filelist.f]
design/bba_pkg.sv
design/bitmap_block_allocator.sv
verif/tb_bitmap_block_allocator.sv
